[rtl/core/gmci_pkg.sv]
// Shared types and constants of the gyro mounting-correction and integration block.
`default_nettype none

package gmci_pkg;

	localparam int COEF_WIDTH      = 16;
	localparam int RATE_IN_WIDTH   = 16;
	localparam int TRUE_RATE_WIDTH = 18;
	localparam int TIME_WIDTH      = 32;
	localparam int DT_WIDTH        = 16;
	localparam int NUM_COEFS       = 8;
	localparam int COEF_SEL_WIDTH  = 3;
	localparam int CFG_INDEX_WIDTH = 4;
	localparam int NUM_AXES        = 3;
	localparam int MUL_A_WIDTH     = TRUE_RATE_WIDTH;
	localparam int MUL_B_WIDTH     = DT_WIDTH + 1;
	localparam int PROD_WIDTH      = MUL_A_WIDTH + MUL_B_WIDTH;
	localparam int SUM_WIDTH       = PROD_WIDTH + 1;
	localparam int TRUE_RATE_MAX   = 2 ** (TRUE_RATE_WIDTH - 1) - 1;
	localparam int TRUE_RATE_MIN   = -(2 ** (TRUE_RATE_WIDTH - 1));

	localparam logic signed [COEF_WIDTH-1:0] COEF_RESET_ONE = 16'sd16384;

	typedef enum logic [COEF_SEL_WIDTH-1:0] {
		REG_CP_CY = 3'd0,
		REG_CR_SY = 3'd1,
		REG_SR_CY = 3'd2,
		REG_CP_SY = 3'd3,
		REG_CR_CY = 3'd4,
		REG_SR_SY = 3'd5,
		REG_SP_CY = 3'd6,
		REG_CR_CP = 3'd7
	} coef_sel_t;

	typedef enum logic [1:0] {
		TERM_X,
		TERM_Y,
		TERM_Z,
		TERM_DT
	} term_t;

	typedef struct packed {
		logic  capture;
		logic  mul_en;
		term_t mul_term;
		logic  sum_clr;
		logic  sum_en;
		logic  rate_en;
		logic  integ_en;
		logic  publish;
	} dp_cmd_t;

endpackage

`default_nettype wire

[rtl/core/gyro_mount_correct_integrate.sv]
// Top level of the gyro mounting-correction and rate integration block.
`default_nettype none

// Each input transfer carries one timestamped three-axis gyro sample. The raw rates pass
// through the eight-coefficient mounting matrix written on the configuration port (reset
// gives the identity), the corrected rates are floored by COEF_FRAC_BITS and saturated to
// 18 bits, and each is multiplied by the tick count since the previous sample (wrapping,
// capped at 65535) and added into a saturating ANGLE_WIDTH-bit angle accumulator. A sample
// with start_of_record set, or the first one after reset, clears the accumulators, only
// sets the reference time and reports zero angles. After its input transfer a sample passes
// through the three matrix-term multiplies in the multiply lanes, the summing and
// saturation of the corrected rates, the multiply and the accumulate of the integration,
// and the loading of the output register, each lane owning one 18 by 17 bit multiplier.
// No new sample is taken while one is in flight. The output register holds a finished
// result while the next sample is being worked on; a new sample is taken once the previous
// one has reached that register.
// Coefficients should be written only while no sample is in flight.
module gyro_mount_correct_integrate #(
	parameter int COEF_FRAC_BITS = 14,
	parameter int ANGLE_WIDTH    = 48
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic                                         in_valid,
	output logic                                              in_stall,
	input  wire logic                                         start_of_record,
	input  wire logic [gmci_pkg::TIME_WIDTH-1:0]              sample_time,
	input  wire logic signed [gmci_pkg::RATE_IN_WIDTH-1:0]    rate_x,
	input  wire logic signed [gmci_pkg::RATE_IN_WIDTH-1:0]    rate_y,
	input  wire logic signed [gmci_pkg::RATE_IN_WIDTH-1:0]    rate_z,
	output logic                                              out_valid,
	input  wire logic                                         out_stall,
	output logic signed [gmci_pkg::TRUE_RATE_WIDTH-1:0]       true_rate_x,
	output logic signed [gmci_pkg::TRUE_RATE_WIDTH-1:0]       true_rate_y,
	output logic signed [gmci_pkg::TRUE_RATE_WIDTH-1:0]       true_rate_z,
	output logic signed [ANGLE_WIDTH-1:0]                     pitch_angle,
	output logic signed [ANGLE_WIDTH-1:0]                     roll_angle,
	output logic signed [ANGLE_WIDTH-1:0]                     yaw_angle,
	input  wire logic                                         cfg_we,
	input  wire logic [gmci_pkg::CFG_INDEX_WIDTH-1:0]         cfg_index,
	input  wire logic [gmci_pkg::COEF_WIDTH-1:0]              cfg_data
);
	import gmci_pkg::*;

	dp_cmd_t cmd;

	gmci_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	gmci_datapath #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.ANGLE_WIDTH    (ANGLE_WIDTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.start_of_record (start_of_record),
		.sample_time     (sample_time),
		.rate_x          (rate_x),
		.rate_y          (rate_y),
		.rate_z          (rate_z),
		.true_rate_x     (true_rate_x),
		.true_rate_y     (true_rate_y),
		.true_rate_z     (true_rate_z),
		.pitch_angle     (pitch_angle),
		.roll_angle      (roll_angle),
		.yaw_angle       (yaw_angle)
	);

	// An input transfer always starts a busy period.
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a sample is in flight");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.sum_clr, cmd.sum_en, cmd.rate_en, cmd.integ_en,
			cmd.publish}))
		else $error("datapath commands overlap");

	// A result is loaded only when the output register is empty or being emptied.
	a_publish_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> !out_valid || !out_stall)
		else $error("result overwrites a pending output");

	a_publish_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> out_valid)
		else $error("loaded result not offered");

endmodule

`default_nettype wire

[rtl/core/gmci_ctrl.sv]
// Sequencing state machine and output valid flag of the gyro integration block.
`default_nettype none

module gmci_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output gmci_pkg::dp_cmd_t     cmd
);
	import gmci_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_T0,
		S_T1,
		S_T2,
		S_SUM,
		S_RATE,
		S_DT,
		S_INTEG,
		S_PUB
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.mul_term = TERM_X;
		unique case (state_q)
			S_IDLE:  cmd.capture = in_valid;
			S_T0: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_term = TERM_X;
			end
			S_T1: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_term = TERM_Y;
				cmd.sum_clr  = 1'b1;
			end
			S_T2: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_term = TERM_Z;
				cmd.sum_en   = 1'b1;
			end
			S_SUM:   cmd.sum_en = 1'b1;
			S_RATE:  cmd.rate_en = 1'b1;
			S_DT: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_term = TERM_DT;
			end
			S_INTEG: cmd.integ_en = 1'b1;
			S_PUB:   cmd.publish = slot_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_T0;
				S_T0:    state_q <= S_T1;
				S_T1:    state_q <= S_T2;
				S_T2:    state_q <= S_SUM;
				S_SUM:   state_q <= S_RATE;
				S_RATE:  state_q <= S_DT;
				S_DT:    state_q <= S_INTEG;
				S_INTEG: state_q <= S_PUB;
				S_PUB:   if (slot_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_PUB && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/gmci_datapath.sv]
// Coefficient registers, three multiply lanes, angle accumulators and output registers.
`default_nettype none

module gmci_datapath #(
	parameter int COEF_FRAC_BITS = 14,
	parameter int ANGLE_WIDTH    = 48
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire gmci_pkg::dp_cmd_t                            cmd,
	input  wire logic                                         cfg_we,
	input  wire logic [gmci_pkg::CFG_INDEX_WIDTH-1:0]         cfg_index,
	input  wire logic [gmci_pkg::COEF_WIDTH-1:0]              cfg_data,
	input  wire logic                                         start_of_record,
	input  wire logic [gmci_pkg::TIME_WIDTH-1:0]              sample_time,
	input  wire logic signed [gmci_pkg::RATE_IN_WIDTH-1:0]    rate_x,
	input  wire logic signed [gmci_pkg::RATE_IN_WIDTH-1:0]    rate_y,
	input  wire logic signed [gmci_pkg::RATE_IN_WIDTH-1:0]    rate_z,
	output logic signed [gmci_pkg::TRUE_RATE_WIDTH-1:0]       true_rate_x,
	output logic signed [gmci_pkg::TRUE_RATE_WIDTH-1:0]       true_rate_y,
	output logic signed [gmci_pkg::TRUE_RATE_WIDTH-1:0]       true_rate_z,
	output logic signed [ANGLE_WIDTH-1:0]                     pitch_angle,
	output logic signed [ANGLE_WIDTH-1:0]                     roll_angle,
	output logic signed [ANGLE_WIDTH-1:0]                     yaw_angle
);
	import gmci_pkg::*;

	logic signed [COEF_WIDTH-1:0]      coef_q [NUM_COEFS];
	logic [TIME_WIDTH-1:0]             prev_time_q;
	logic                              have_prev_q;
	logic                              first_q;
	logic [DT_WIDTH-1:0]               dt_q;
	logic signed [RATE_IN_WIDTH-1:0]   x_q, y_q, z_q;

	logic signed [PROD_WIDTH-1:0]      prod_s1   [NUM_AXES];
	logic [NUM_AXES-1:0]               neg_s1;
	logic signed [SUM_WIDTH-1:0]       sum_q     [NUM_AXES];
	logic signed [TRUE_RATE_WIDTH-1:0] rate_q    [NUM_AXES];
	logic signed [ANGLE_WIDTH-1:0]     angle_q   [NUM_AXES];
	logic signed [TRUE_RATE_WIDTH-1:0] out_rate_q  [NUM_AXES];
	logic signed [ANGLE_WIDTH-1:0]     out_angle_q [NUM_AXES];

	logic [TIME_WIDTH-1:0]             time_diff;
	logic [DT_WIDTH-1:0]               dt_sat;
	logic signed [MUL_A_WIDTH-1:0]     mul_a     [NUM_AXES];
	logic signed [MUL_B_WIDTH-1:0]     mul_b     [NUM_AXES];
	logic [NUM_AXES-1:0]               term_neg;
	logic signed [RATE_IN_WIDTH-1:0]   term_rate;
	logic signed [SUM_WIDTH-1:0]       prod_term [NUM_AXES];
	logic signed [SUM_WIDTH-1:0]       shifted   [NUM_AXES];
	logic signed [TRUE_RATE_WIDTH-1:0] rate_sat  [NUM_AXES];
	logic signed [ANGLE_WIDTH:0]       angle_sum [NUM_AXES];
	logic signed [ANGLE_WIDTH-1:0]     angle_new [NUM_AXES];

	assign time_diff = sample_time - prev_time_q;
	assign dt_sat    = (|time_diff[TIME_WIDTH-1:DT_WIDTH]) ? '1 : time_diff[DT_WIDTH-1:0];

	always_comb begin
		term_rate = x_q;
		term_neg  = '0;
		for (int k = 0; k < NUM_AXES; k++) begin
			mul_a[k] = '0;
			mul_b[k] = '0;
		end
		case (cmd.mul_term)
			TERM_X: begin
				term_rate = x_q;
				mul_b[0]  = MUL_B_WIDTH'(coef_q[REG_CP_CY]);
				mul_b[1]  = MUL_B_WIDTH'(coef_q[REG_CP_SY]);
				mul_b[2]  = MUL_B_WIDTH'(coef_q[REG_SP_CY]);
				term_neg  = 3'b100;
			end
			TERM_Y: begin
				term_rate = y_q;
				mul_b[0]  = MUL_B_WIDTH'(coef_q[REG_CR_SY]);
				mul_b[1]  = MUL_B_WIDTH'(coef_q[REG_CR_CY]);
				mul_b[2]  = MUL_B_WIDTH'(coef_q[REG_SR_SY]);
				term_neg  = 3'b001;
			end
			TERM_Z: begin
				term_rate = z_q;
				mul_b[0]  = MUL_B_WIDTH'(coef_q[REG_SR_CY]);
				mul_b[1]  = MUL_B_WIDTH'(coef_q[REG_SR_SY]);
				mul_b[2]  = MUL_B_WIDTH'(coef_q[REG_CR_CP]);
				term_neg  = 3'b010;
			end
			default: begin
				term_rate = x_q;
				term_neg  = '0;
			end
		endcase
		for (int k = 0; k < NUM_AXES; k++) begin
			if (cmd.mul_term == TERM_DT) begin
				mul_a[k] = rate_q[k];
				mul_b[k] = $signed({1'b0, dt_q});
			end else begin
				mul_a[k] = MUL_A_WIDTH'(term_rate);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_AXES; k++) begin
			prod_term[k] = neg_s1[k] ? -SUM_WIDTH'(prod_s1[k]) : SUM_WIDTH'(prod_s1[k]);
			shifted[k]   = sum_q[k] >>> COEF_FRAC_BITS;
			if (shifted[k] > $signed(SUM_WIDTH'(TRUE_RATE_MAX))) begin
				rate_sat[k] = TRUE_RATE_WIDTH'(TRUE_RATE_MAX);
			end else if (shifted[k] < $signed(SUM_WIDTH'(TRUE_RATE_MIN))) begin
				rate_sat[k] = TRUE_RATE_WIDTH'(TRUE_RATE_MIN);
			end else begin
				rate_sat[k] = shifted[k][TRUE_RATE_WIDTH-1:0];
			end
			angle_sum[k] = (ANGLE_WIDTH + 1)'(angle_q[k]) + (ANGLE_WIDTH + 1)'(prod_s1[k]);
			if (angle_sum[k][ANGLE_WIDTH] != angle_sum[k][ANGLE_WIDTH-1]) begin
				angle_new[k] = angle_sum[k][ANGLE_WIDTH] ?
					{1'b1, {(ANGLE_WIDTH - 1){1'b0}}} : {1'b0, {(ANGLE_WIDTH - 1){1'b1}}};
			end else begin
				angle_new[k] = angle_sum[k][ANGLE_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++) begin
				if (i == int'(REG_CP_CY) || i == int'(REG_CR_CY) || i == int'(REG_CR_CP)) begin
					coef_q[i] <= COEF_RESET_ONE;
				end else begin
					coef_q[i] <= '0;
				end
			end
			prev_time_q       <= '0;
			have_prev_q       <= 1'b0;
			for (int k = 0; k < NUM_AXES; k++) begin
				angle_q[k] <= '0;
			end
		end else begin
			if (cfg_we && cfg_index < CFG_INDEX_WIDTH'(NUM_COEFS)) begin
				coef_q[cfg_index[COEF_SEL_WIDTH-1:0]] <= cfg_data;
			end
			if (cmd.capture) begin
				prev_time_q <= sample_time;
				have_prev_q <= 1'b1;
			end
			if (cmd.integ_en) begin
				for (int k = 0; k < NUM_AXES; k++) begin
					angle_q[k] <= first_q ? '0 : angle_new[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q     <= rate_x;
			y_q     <= rate_y;
			z_q     <= rate_z;
			first_q <= start_of_record || !have_prev_q;
			dt_q    <= dt_sat;
		end
		for (int k = 0; k < NUM_AXES; k++) begin
			if (cmd.mul_en) begin
				prod_s1[k] <= mul_a[k] * mul_b[k];
				neg_s1[k]  <= term_neg[k];
			end
			if (cmd.sum_clr) begin
				sum_q[k] <= prod_term[k];
			end else if (cmd.sum_en) begin
				sum_q[k] <= sum_q[k] + prod_term[k];
			end
			if (cmd.rate_en) begin
				rate_q[k] <= rate_sat[k];
			end
			if (cmd.publish) begin
				out_rate_q[k]  <= rate_q[k];
				out_angle_q[k] <= angle_q[k];
			end
		end
	end

	assign true_rate_x = out_rate_q[0];
	assign true_rate_y = out_rate_q[1];
	assign true_rate_z = out_rate_q[2];
	assign pitch_angle = out_angle_q[0];
	assign roll_angle  = out_angle_q[1];
	assign yaw_angle   = out_angle_q[2];

endmodule

`default_nettype wire
